FILE: src/trs_pkg.sv
// Shared types, constants and helpers for the TRS model matrix builder.
// Used by the CORDIC pipeline, the matrix pipeline and the top level.
package trs_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [30:0] TURN_PER_RAD = 31'sd683565276;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [23:0] ent_t;
    typedef logic signed [15:0] s16_t;
    typedef logic signed [31:0] s32_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sc_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Rounded Q30 product.
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b) + 64'sd536870912;
            return q30_t'(p >>> 30);
        end
    endfunction

endpackage

FILE: src/trs_cordic.sv
// Pipelined sine/cosine unit: angle conversion, quadrant fold, 24 CORDIC stages.
// Depends on trs_pkg; stalls with a shared enable.
module trs_cordic (
    input  logic                aclk,
    input  logic                en,
    input  trs_pkg::s16_t       angle,
    output trs_pkg::sc_t        result
);
    import trs_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [47:0] prod_reg;
    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic               flip_reg [N+1];
    q30_t               s_reg, c_reg;

    logic signed [31:0] bam;
    logic signed [33:0] z0;
    logic               f0;

    always_comb begin
        bam = 32'(prod_reg >>> 12);
        z0 = 34'(bam);
        f0 = 1'b0;
        if (z0 > 34'sd1073741824) begin
            z0 = z0 - 34'sd2147483648;
            f0 = 1'b1;
        end else if (z0 < -34'sd1073741824) begin
            z0 = z0 + 34'sd2147483648;
            f0 = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 48'(angle) * 48'(TURN_PER_RAD) + 48'sd2048;
            x_reg[0] <= 34'(CORDIC_GAIN);
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            flip_reg[0] <= f0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 34'(atan_bam(5'(i)));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 34'(atan_bam(5'(i)));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= flip_reg[N] ? -q30_t'(y_reg[N]) : q30_t'(y_reg[N]);
            c_reg <= flip_reg[N] ? -q30_t'(x_reg[N]) : q30_t'(x_reg[N]);
        end
    end

    assign result.s = s_reg;
    assign result.c = c_reg;
endmodule

FILE: src/trs_matrix.sv
// Matrix stages: rotation products in two rounds, then scaling and saturation.
// Depends on trs_pkg; stalls with a shared enable.
module trs_matrix (
    input  logic                aclk,
    input  logic                en,
    input  trs_pkg::sc_t        ax,
    input  trs_pkg::sc_t        ay,
    input  trs_pkg::sc_t        az,
    input  trs_pkg::s16_t       scale_x,
    input  trs_pkg::s16_t       scale_y,
    input  trs_pkg::s16_t       scale_z,
    output trs_pkg::ent_t       ent [9]
);
    import trs_pkg::*;

    q30_t zy_reg, wy_reg, r0_reg, r3_reg, r6_reg, r7_reg, r8_reg;
    sc_t  x1_reg, z1_reg;
    q30_t r_reg [9];
    ent_t e_reg [9];
    s16_t sc_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            zy_reg <= mul30(az.c, ay.s);
            wy_reg <= mul30(az.s, ay.s);
            r0_reg <= mul30(az.c, ay.c);
            r3_reg <= mul30(az.s, ay.c);
            r6_reg <= -ay.s;
            r7_reg <= mul30(ay.c, ax.s);
            r8_reg <= mul30(ay.c, ax.c);
            x1_reg <= ax;
            z1_reg <= az;
            r_reg[0] <= r0_reg;
            r_reg[1] <= mul30(zy_reg, x1_reg.s) - mul30(z1_reg.s, x1_reg.c);
            r_reg[2] <= mul30(zy_reg, x1_reg.c) + mul30(z1_reg.s, x1_reg.s);
            r_reg[3] <= r3_reg;
            r_reg[4] <= mul30(wy_reg, x1_reg.s) + mul30(z1_reg.c, x1_reg.c);
            r_reg[5] <= mul30(wy_reg, x1_reg.c) - mul30(z1_reg.c, x1_reg.s);
            r_reg[6] <= r6_reg;
            r_reg[7] <= r7_reg;
            r_reg[8] <= r8_reg;
        end
    end

    // Scale factors are aligned by the caller to the second product round.
    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg[0] <= scale_x;
            sc_reg[1] <= scale_y;
            sc_reg[2] <= scale_z;
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_sc
        logic signed [49:0] p;
        logic signed [27:0] v;
        always_comb begin
            p = 50'(r_reg[k]) * 50'(sc_reg[k % 3]) + 50'sd2097152;
            v = 28'(p >>> 22);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (v > 28'sd8388607) begin
                    e_reg[k] <= 24'sd8388607;
                end else if (v < -28'sd8388608) begin
                    e_reg[k] <= -24'sd8388608;
                end else begin
                    e_reg[k] <= 24'(v);
                end
            end
        end
        assign ent[k] = e_reg[k];
    end
endmodule

FILE: src/trs_model_matrix_builder.sv
// Top level of the TRS model matrix builder: stream ports and pipeline control.
// Depends on trs_pkg, trs_cordic and trs_matrix.
// The block takes one request per cycle while its output is not stalled and returns
// M = T*Rz*Ry*Rx*S. A request passes through the sine/cosine units (conversion,
// quadrant fold, 24 CORDIC stages, sign fix) and then the product and scaling stages. The whole
// pipeline advances whenever its last stage is empty or being read, so a full
// pipeline sustains one request per cycle.
module trs_model_matrix_builder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
    input  logic [191:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // m_r0c0..m_r2c2 (24 bits each), t_x, t_y, t_z (32 bits each)
    output logic [311:0]  m_tdata
);
    import trs_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 6;

    logic              en;
    logic [DEPTH-1:0]  v_reg;
    s16_t              scl_reg [CORDIC_STEPS+4][3];
    s32_t              pos_reg [DEPTH][3];
    sc_t               ax, ay, az;
    ent_t              ent [9];

    assign en = !v_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                scl_reg[0][j] <= s_tdata[48 + 16*j +: 16];
                pos_reg[0][j] <= s_tdata[96 + 32*j +: 32];
            end
            for (int i = 1; i < CORDIC_STEPS + 4; i++) begin
                scl_reg[i] <= scl_reg[i-1];
            end
            for (int i = 1; i < DEPTH; i++) begin
                pos_reg[i] <= pos_reg[i-1];
            end
        end
    end

    trs_cordic u_cx (.aclk, .en, .angle(s_tdata[15:0]),  .result(ax));
    trs_cordic u_cy (.aclk, .en, .angle(s_tdata[31:16]), .result(ay));
    trs_cordic u_cz (.aclk, .en, .angle(s_tdata[47:32]), .result(az));

    trs_matrix u_mat (
        .aclk, .en, .ax, .ay, .az,
        .scale_x(scl_reg[CORDIC_STEPS+3][0]),
        .scale_y(scl_reg[CORDIC_STEPS+3][1]),
        .scale_z(scl_reg[CORDIC_STEPS+3][2]),
        .ent
    );

    for (genvar k = 0; k < 9; k++) begin : g_out
        assign m_tdata[24*k +: 24] = ent[k];
    end
    assign m_tdata[216 +: 32] = pos_reg[DEPTH-1][0];
    assign m_tdata[248 +: 32] = pos_reg[DEPTH-1][1];
    assign m_tdata[280 +: 32] = pos_reg[DEPTH-1][2];

    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    ap_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    ap_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

FILE: test/tb_top.sv
// Testbench for trs_model_matrix_builder: drives transform requests over the
// input stream and checks every matrix against a predictor built on trs_pkg types.
// Depends on trs_pkg and the RTL of the block only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import trs_pkg::*;

    typedef struct packed {
        s32_t pos_z, pos_y, pos_x;
        s16_t scale_z, scale_y, scale_x;
        s16_t angle_z, angle_y, angle_x;
    } xform_t;

    typedef struct packed {
        s32_t t_z, t_y, t_x;
        ent_t r22, r21, r20, r12, r11, r10, r02, r01, r00;
    } matrix_t;

    localparam int RAND_ITEMS = 530;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 200000;
    localparam s16_t ONE_Q8 = 16'sd256;
    localparam s16_t S16_MAX = 16'sh7fff;
    localparam s16_t S16_MIN = 16'sh8000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [191:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [311:0] m_tdata;

    matrix_t matrix_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int requests_sent = 0;
    longint cycles = 0;

    trs_model_matrix_builder u_top (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(input s16_t a, output longint sn, output longint cs);
        longint prod, z, x, y, dx, dy;
        logic [31:0] turn;
        bit flip;
        prod = longint'(a) * 64'sd683565276 + 2048;
        turn = prod[43:12];
        z = longint'(signed'(turn));
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(atan_bam(5'(i)));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(atan_bam(5'(i)));
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint q30_product(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic ent_t scaled_entry(longint r, s16_t sc);
        longint v;
        v = (r * longint'(sc) + (64'sd1 <<< 21)) >>> 22;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return ent_t'(v);
    endfunction

    function automatic matrix_t build_matrix(xform_t t);
        longint sx, cx, sy, cy, sz, cz, zy, wy;
        matrix_t m;
        sin_cos(t.angle_x, sx, cx);
        sin_cos(t.angle_y, sy, cy);
        sin_cos(t.angle_z, sz, cz);
        zy = q30_product(cz, sy);
        wy = q30_product(sz, sy);
        m.r00 = scaled_entry(q30_product(cz, cy), t.scale_x);
        m.r01 = scaled_entry(q30_product(zy, sx) - q30_product(sz, cx), t.scale_y);
        m.r02 = scaled_entry(q30_product(zy, cx) + q30_product(sz, sx), t.scale_z);
        m.r10 = scaled_entry(q30_product(sz, cy), t.scale_x);
        m.r11 = scaled_entry(q30_product(wy, sx) + q30_product(cz, cx), t.scale_y);
        m.r12 = scaled_entry(q30_product(wy, cx) - q30_product(cz, sx), t.scale_z);
        m.r20 = scaled_entry(-sy, t.scale_x);
        m.r21 = scaled_entry(q30_product(cy, sx), t.scale_y);
        m.r22 = scaled_entry(q30_product(cy, cx), t.scale_z);
        m.t_x = t.pos_x;
        m.t_y = t.pos_y;
        m.t_z = t.pos_z;
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s in result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_request(xform_t t);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        do @(posedge aclk); while (!s_tready);
        matrix_q.push_back(build_matrix(t));
        requests_sent++;
    endtask

    function automatic xform_t random_xform();
        xform_t t;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                t.scale_x = s16_t'($urandom_range(0, 1024)) - 16'sd512;
                t.scale_y = s16_t'($urandom_range(0, 1024)) - 16'sd512;
                t.scale_z = s16_t'($urandom_range(0, 1024)) - 16'sd512;
                t.angle_x = s16_t'($urandom_range(0, 25736)) - 16'sd12868;
                t.angle_y = s16_t'($urandom_range(0, 25736)) - 16'sd12868;
                t.angle_z = s16_t'($urandom_range(0, 25736)) - 16'sd12868;
            end
            1: begin
                t.scale_x = ONE_Q8;
                t.scale_y = ONE_Q8;
                t.scale_z = ONE_Q8;
            end
            default: ;
        endcase
        return t;
    endfunction

    // Receiver: random per-result stall, plus one long hold-off counted here.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        matrix_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (matrix_q.size() == 0) begin
                $display("unexpected result %0d with nothing outstanding", results_seen);
                mismatches++;
            end else begin
                want = matrix_q.pop_front();
                if (got.r00 !== want.r00) report_mismatch("r0c0", got.r00, want.r00);
                if (got.r01 !== want.r01) report_mismatch("r0c1", got.r01, want.r01);
                if (got.r02 !== want.r02) report_mismatch("r0c2", got.r02, want.r02);
                if (got.r10 !== want.r10) report_mismatch("r1c0", got.r10, want.r10);
                if (got.r11 !== want.r11) report_mismatch("r1c1", got.r11, want.r11);
                if (got.r12 !== want.r12) report_mismatch("r1c2", got.r12, want.r12);
                if (got.r20 !== want.r20) report_mismatch("r2c0", got.r20, want.r20);
                if (got.r21 !== want.r21) report_mismatch("r2c1", got.r21, want.r21);
                if (got.r22 !== want.r22) report_mismatch("r2c2", got.r22, want.r22);
                if (got.t_x !== want.t_x) report_mismatch("t_x", got.t_x, want.t_x);
                if (got.t_y !== want.t_y) report_mismatch("t_y", got.t_y, want.t_y);
                if (got.t_z !== want.t_z) report_mismatch("t_z", got.t_z, want.t_z);
            end
            results_seen++;
        end
    end

    typedef struct {
        xform_t req;
        bit typed;
        ent_t r00, r11, r22;
    } table_row_t;

    table_row_t directed[$];

    function automatic xform_t make_xform(s16_t ax, s16_t ay, s16_t az, s16_t sx,
                                          s16_t sy, s16_t sz, s32_t px, s32_t py,
                                          s32_t pz);
        xform_t t;
        t.angle_x = ax; t.angle_y = ay; t.angle_z = az;
        t.scale_x = sx; t.scale_y = sy; t.scale_z = sz;
        t.pos_x = px; t.pos_y = py; t.pos_z = pz;
        return t;
    endfunction

    function automatic void add_row(xform_t t, bit typed, ent_t d0, ent_t d1, ent_t d2);
        table_row_t row;
        row.req = t; row.typed = typed;
        row.r00 = d0; row.r11 = d1; row.r22 = d2;
        directed.push_back(row);
    endfunction

    initial begin
        int pause;
        s16_t ang[];
        ang = '{16'sd0, 16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868, S16_MAX,
                S16_MIN, 16'sd25736, 16'sd1, -16'sd1};
        // Identity, full-scale factors, zero scale and pass-through of extreme positions.
        add_row(make_xform(16'sd0, 16'sd0, 16'sd0, ONE_Q8, ONE_Q8, ONE_Q8,
                           32'sd0, 32'sd0, 32'sd0), 1'b0, 24'sd0, 24'sd0, 24'sd0);
        add_row(make_xform(16'sd0, 16'sd0, 16'sd0, S16_MAX, S16_MAX, S16_MAX,
                           32'sh7fffffff, 32'sh80000000, -32'sd1),
                1'b0, 24'sd0, 24'sd0, 24'sd0);
        add_row(make_xform(16'sd0, 16'sd0, 16'sd0, S16_MIN, S16_MIN, S16_MIN,
                           32'sh80000000, 32'sh7fffffff, 32'sd0),
                1'b0, 24'sd0, 24'sd0, 24'sd0);
        add_row(make_xform(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                           32'sd1, -32'sd1, 32'sd65536), 1'b1, 24'sd0, 24'sd0, 24'sd0);
        foreach (ang[i]) begin
            add_row(make_xform(ang[i], 16'sd0, 16'sd0, ONE_Q8, ONE_Q8, ONE_Q8,
                               32'sd0, 32'sd0, 32'sd0), 1'b0, 24'sd0, 24'sd0, 24'sd0);
            add_row(make_xform(16'sd0, ang[i], ang[i], -ONE_Q8, ONE_Q8, 16'sd1,
                               32'sd0, 32'sd0, 32'sd0), 1'b0, 24'sd0, 24'sd0, 24'sd0);
        end
        add_row(make_xform(S16_MAX, S16_MIN, S16_MAX, S16_MAX, S16_MIN, S16_MAX,
                           -32'sd1, -32'sd1, -32'sd1), 1'b0, 24'sd0, 24'sd0, 24'sd0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].typed) begin
                matrix_t m;
                m = build_matrix(directed[i].req);
                if (m.r00 !== directed[i].r00 || m.r11 !== directed[i].r11 ||
                    m.r22 !== directed[i].r22)
                    report_mismatch("directed diagonal", m.r00, directed[i].r00);
            end
            send_request(directed[i].req);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            send_request(random_xform());
        end
        s_tvalid <= 1'b0;

        pause = 0;
        while (matrix_q.size() != 0 && pause < 20000) begin
            @(posedge aclk);
            pause++;
        end
        repeat (40) @(posedge aclk);
        $display("Sent %0d transform requests (directed extremes and random); %0d matrices",
                 requests_sent, results_seen);
        $display("checked field by field, with a long output stall midway.");
        if (mismatches == 0 && matrix_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

FILE: trs_model_matrix_builder.f
src/trs_pkg.sv
src/trs_cordic.sv
src/trs_matrix.sv
src/trs_model_matrix_builder.sv
test/tb_top.sv
